// ===== design/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// bma_pkg: shared types and codes for the buddy allocator
// Node codes of the allocation tree, response status codes, command codes, RAM port controls.
// ----------------------------------------------------------------------------
`default_nettype none

package bma_pkg;

	// tree node codes
	typedef enum logic [1:0] {
		NODE_UNUSED = 2'd0,
		NODE_FREE   = 2'd1,
		NODE_ALLOC  = 2'd2,
		NODE_SPLIT  = 2'd3
	} node_t;

	// response status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// memory port controls
	typedef struct packed {
		logic  re;
		logic  we;
		node_t wdata;
	} ram_ctl_t;

endpackage

`default_nettype wire

// ===== design/bma_req_if.sv =====
// ----------------------------------------------------------------------------
// bma_req_if: request channel of the buddy allocator
// Valid/ready handshake carrying one allocate or free command.
// ----------------------------------------------------------------------------
`default_nettype none

interface bma_req_if #(
	parameter int ORDER = 10
);
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [ORDER:0]   req_size;
	logic [ORDER-1:0] free_offset;

	modport source (output valid, cmd, req_size, free_offset, input ready);
	modport sink   (input valid, cmd, req_size, free_offset, output ready);
endinterface

`default_nettype wire

// ===== design/bma_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bma_rsp_if: response channel of the buddy allocator
// Valid/ready handshake carrying status, block offset and block size.
// ----------------------------------------------------------------------------
`default_nettype none

interface bma_rsp_if #(
	parameter int ORDER = 10
);
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [ORDER-1:0] block_offset;
	logic [ORDER:0]   block_size;

	modport source (output valid, status, block_offset, block_size, input ready);
	modport sink   (input valid, status, block_offset, block_size, output ready);
endinterface

`default_nettype wire

// ===== design/bma_node_ram.sv =====
// ----------------------------------------------------------------------------
// bma_node_ram: node status memory of the allocation tree
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bma_node_ram #(
	parameter int AW = 11
) (
	input  wire                 clk,
	input  bma_pkg::ram_ctl_t   ctl,
	input  wire [AW-1:0]        raddr,
	input  wire [AW-1:0]        waddr,
	output bma_pkg::node_t      rdata
);
	import bma_pkg::*;

	node_t mem [0:(1<<AW)-1];

	// write and registered read
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/buddy_memory_allocator_unit.sv =====
// Allocate scans the tree in address order, reading each node visited on the way
// to a leaf, then splits the found block down to fit the request; free descends one
// level at a time and then merges with each free buddy on the way up. One request at
// a time, sequenced over the node memory. Reset: a clearing pass over every node address
// rewrites the node memory (root free, rest unused); no request is taken then.
// ----------------------------------------------------------------------------
// buddy_memory_allocator_unit: buddy allocator over a pool of 2^ORDER units
// Tree of node codes in a synchronous memory, walked by a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_memory_allocator_unit #(
	parameter int ORDER = 10
) (
	input  wire     clk,
	input  wire     arst_n,
	bma_req_if.sink   req,
	bma_rsp_if.source rsp
);
	import bma_pkg::*;

	localparam int AW = ORDER + 1;
	localparam logic [ORDER:0] POOL = {1'b1, {ORDER{1'b0}}};
	localparam logic [AW-1:0]  ROOT = {{(AW-1){1'b0}}, 1'b1};

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_A_UP, S_A_SPL, S_A_SPL2,
		S_F_RD, S_F_CHK, S_M_RD, S_M_CHK, S_M_W2, S_OUT
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    idx_q;
	logic [ORDER-1:0] base_q;
	logic [ORDER:0]   size_q;
	logic [ORDER:0]   r_q;
	logic [ORDER-1:0] off_q;
	logic [1:0]       res_status_q;
	logic [ORDER-1:0] res_offset_q;
	logic [ORDER:0]   res_size_q;
	logic             rsp_valid_q;
	logic [1:0]       rsp_status_q;
	logic [ORDER-1:0] rsp_offset_q;
	logic [ORDER:0]   rsp_size_q;

	ram_ctl_t      ctl;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	node_t         rdata;

	logic [ORDER:0]   half;
	logic [ORDER:0]   mid;
	logic [ORDER:0]   r_eff;
	logic [AW-1:0]    sib;

	assign half  = size_q >> 1;
	assign mid   = {1'b0, base_q} + half;
	assign r_eff = (req.req_size == '0) ? {{ORDER{1'b0}}, 1'b1} : req.req_size;
	assign sib   = idx_q ^ ROOT;

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.block_offset = rsp_offset_q;
	assign rsp.block_size   = rsp_size_q;

	bma_node_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.ctl   (ctl),
		.raddr (raddr),
		.waddr (waddr),
		.rdata (rdata)
	);

	// memory port control per state
	always_comb begin
		ctl.re    = 1'b0;
		ctl.we    = 1'b0;
		ctl.wdata = NODE_UNUSED;
		raddr     = idx_q;
		waddr     = idx_q;
		case (state_q)
			S_CLEAR: begin
				ctl.we    = 1'b1;
				waddr     = clr_q;
				ctl.wdata = (clr_q == ROOT) ? NODE_FREE : NODE_UNUSED;
			end
			S_A_RD, S_F_RD: begin
				ctl.re = 1'b1;
			end
			S_A_SPL: begin
				ctl.we    = 1'b1;
				ctl.wdata = (size_q > 1 && half >= r_q) ? NODE_SPLIT : NODE_ALLOC;
			end
			S_A_SPL2: begin
				ctl.we    = 1'b1;
				waddr     = {idx_q[AW-2:0], 1'b1};
				ctl.wdata = NODE_FREE;
			end
			S_M_RD: begin
				if (idx_q == ROOT) begin
					ctl.we    = 1'b1;
					ctl.wdata = NODE_FREE;
				end else begin
					ctl.re = 1'b1;
					raddr  = sib;
				end
			end
			S_M_CHK: begin
				ctl.we = 1'b1;
				if (rdata == NODE_FREE) begin
					waddr     = sib;
					ctl.wdata = NODE_UNUSED;
				end else begin
					ctl.wdata = NODE_FREE;
				end
			end
			S_M_W2: begin
				ctl.we    = 1'b1;
				ctl.wdata = NODE_UNUSED;
			end
			default: begin
			end
		endcase
	end

	// sequencer and registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the response once taken
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						idx_q  <= ROOT;
						base_q <= '0;
						size_q <= POOL;
						r_q    <= r_eff;
						off_q  <= req.free_offset;
						if (req.cmd == CMD_FREE) begin
							state_q <= S_F_RD;
						end else if (r_eff > POOL) begin
							res_status_q <= ST_NOFIT;
							res_offset_q <= '0;
							res_size_q   <= '0;
							state_q      <= S_OUT;
						end else begin
							state_q <= S_A_RD;
						end
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (rdata == NODE_SPLIT && size_q > 1) begin
						idx_q   <= {idx_q[AW-2:0], 1'b0};
						size_q  <= half;
						state_q <= S_A_RD;
					end else if (rdata == NODE_FREE && size_q >= r_q) begin
						state_q <= S_A_SPL;
					end else begin
						state_q <= S_A_UP;
					end
				end
				// advance to the next node in address order; no fit once back at the root
				S_A_UP: begin
					if (idx_q == ROOT) begin
						res_status_q <= ST_NOFIT;
						res_offset_q <= '0;
						res_size_q   <= '0;
						state_q      <= S_OUT;
					end else if (idx_q[0]) begin
						idx_q  <= idx_q >> 1;
						base_q <= base_q - size_q[ORDER-1:0];
						size_q <= size_q << 1;
					end else begin
						idx_q   <= idx_q + 1'b1;
						base_q  <= base_q + size_q[ORDER-1:0];
						state_q <= S_A_RD;
					end
				end
				S_A_SPL: begin
					if (size_q > 1 && half >= r_q) begin
						state_q <= S_A_SPL2;
					end else begin
						res_status_q <= ST_OK;
						res_offset_q <= base_q;
						res_size_q   <= size_q;
						state_q      <= S_OUT;
					end
				end
				S_A_SPL2: begin
					idx_q   <= {idx_q[AW-2:0], 1'b0};
					size_q  <= half;
					state_q <= S_A_SPL;
				end
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					if (rdata == NODE_SPLIT && size_q > 1) begin
						size_q <= half;
						if ({1'b0, off_q} >= mid) begin
							base_q <= mid[ORDER-1:0];
							idx_q  <= {idx_q[AW-2:0], 1'b1};
						end else begin
							idx_q <= {idx_q[AW-2:0], 1'b0};
						end
						state_q <= S_F_RD;
					end else if (rdata != NODE_ALLOC || base_q != off_q) begin
						res_status_q <= ST_UNKNOWN;
						res_offset_q <= '0;
						res_size_q   <= '0;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_M_RD;
					end
				end
				S_M_RD: begin
					if (idx_q == ROOT) begin
						res_status_q <= ST_OK;
						res_offset_q <= base_q;
						res_size_q   <= size_q;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_M_CHK;
					end
				end
				S_M_CHK: begin
					if (rdata == NODE_FREE) begin
						state_q <= S_M_W2;
					end else begin
						res_status_q <= ST_OK;
						res_offset_q <= base_q;
						res_size_q   <= size_q;
						state_q      <= S_OUT;
					end
				end
				// merge into the parent
				S_M_W2: begin
					if (idx_q[0]) begin
						base_q <= base_q - size_q[ORDER-1:0];
					end
					size_q  <= size_q << 1;
					idx_q   <= idx_q >> 1;
					state_q <= S_M_RD;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_offset_q <= res_offset_q;
						rsp_size_q   <= res_size_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
